// ----- rtl/pce_pkg.sv -----
// Shared constants, types and helper functions of the polygon clipper.
`timescale 1ns / 1ps
package pce_pkg;

   localparam int MaxClipVerts = 16;
   localparam int BufVerts     = 32;
   localparam int CoordBits    = 16;
   localparam int MinClipVerts = 3;

   localparam int DiffBits     = CoordBits + 1;
   localparam int CrossBits    = 2 * DiffBits + 1;
   localparam int ProdBits     = CrossBits + DiffBits;
   localparam int AccBits      = ProdBits + 1;
   localparam int QuotBits     = CoordBits + 1;
   localparam int RemBits      = CrossBits + 1;
   localparam int QuotCntBits  = $clog2(QuotBits + 1);
   localparam int VertBits     = 2 * CoordBits;
   localparam int SubCntBits   = $clog2(BufVerts + 1);
   localparam int SubIdxBits   = $clog2(BufVerts);
   localparam int ClipCntBits  = $clog2(MaxClipVerts + 1);
   localparam int ClipIdxBits  = $clog2(MaxClipVerts);

   localparam logic FUNC_SUBJECT = 1'b0;
   localparam logic FUNC_CLIP    = 1'b1;

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic signed [DiffBits-1:0]  diff_type;
   typedef logic signed [CrossBits-1:0] cross_type;
   typedef logic signed [AccBits-1:0]   acc_type;
   typedef logic signed [1:0]           sgn_type;

   localparam sgn_type SGN_NEG  = 2'sb11;
   localparam sgn_type SGN_ZERO = 2'sb00;
   localparam sgn_type SGN_POS  = 2'sb01;

   typedef enum logic [5:0] {
      ST_IDLE, ST_DIR_RD0, ST_DIR_RD1, ST_DIR_RD2, ST_DIR_RD3,
      ST_EDGE_CHK, ST_EDGE_RA, ST_EDGE_RB, ST_VCAP,
      ST_SM1, ST_SM2, ST_SM3, ST_SDEC, ST_POST,
      ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_C8,
      ST_CX1, ST_CX2, ST_CX3, ST_CX4, ST_DIVW, ST_CPUSH,
      ST_EMIT_SET, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_HOLD
   } state_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
   } acc_op_type;

   typedef enum logic [2:0] {
      MUL_SIDE1, MUL_SIDE2, MUL_DEN1, MUL_DEN2,
      MUL_NUM1, MUL_NUM2, MUL_BASE, MUL_STEP
   } mul_sel_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
   } mac_ctl_type;

   function automatic diff_type sub_c(coord_type a, coord_type b);
      return diff_type'({a[CoordBits-1], a} - {b[CoordBits-1], b});
   endfunction

   function automatic diff_type ext_c(coord_type a);
      return diff_type'({a[CoordBits-1], a});
   endfunction

   function automatic cross_type ext_d(diff_type d);
      return cross_type'({{(CrossBits-DiffBits){d[DiffBits-1]}}, d});
   endfunction

   function automatic sgn_type sign_of(acc_type a);
      sgn_type s;
      if (a[AccBits-1]) begin
         s = SGN_NEG;
      end else if (a != '0) begin
         s = SGN_POS;
      end else begin
         s = SGN_ZERO;
      end
      return s;
   endfunction

   function automatic sgn_type neg_sgn(sgn_type s);
      return sgn_type'(-s);
   endfunction

endpackage

// ----- rtl/pce_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pce_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pce_mac.sv -----
// Shared signed multiplier with a registered product and an accumulator.
`timescale 1ns / 1ps
module pce_mac
   import pce_pkg::*;
(
   input  logic                          clock,
   input  mac_ctl_type                   ctl,
   input  logic signed [CrossBits-1:0]   op_a,
   input  logic signed [DiffBits-1:0]    op_b,
   output acc_type                       acc
);

   logic signed [ProdBits-1:0] prod_in, prod_ff;
   acc_type                    prod_ext;
   acc_type                    acc_in, acc_ff;

   assign prod_in  = op_a * op_b;
   assign prod_ext = acc_type'({prod_ff[ProdBits-1], prod_ff});

   always_comb begin
      unique case (ctl.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         ACC_SUB:  acc_in = acc_ff - prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- rtl/pce_div.sv -----
// Serial restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module pce_div
   import pce_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  acc_type              dividend,
   input  logic [CrossBits-1:0] divisor,
   output logic                 busy,
   output coord_type            quotient
);

   logic [RemBits-1:0]     rem_ff, rem_in;
   logic [QuotBits-1:0]    low_ff, low_in;
   logic [QuotCntBits-1:0] cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   neg_ff, neg_in;
   logic [CrossBits-1:0]   den_ff, den_in;
   logic [AccBits-1:0]     mag;
   logic [RemBits:0]       trial;
   logic [RemBits:0]       den_ext;
   logic [QuotBits-1:0]    q_signed;

   assign mag     = dividend[AccBits-1] ? AccBits'(-dividend) : AccBits'(dividend);
   assign trial   = {rem_ff, low_ff[QuotBits-1]};
   assign den_ext = {{(RemBits+1-CrossBits){1'b0}}, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      if (start) begin
         rem_in  = mag[AccBits-1:QuotBits];
         low_in  = mag[QuotBits-1:0];
         cnt_in  = QuotCntBits'(QuotBits);
         busy_in = 1'b1;
         neg_in  = dividend[AccBits-1];
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= den_ext) begin
            rem_in = RemBits'(trial - den_ext);
            low_in = {low_ff[QuotBits-2:0], 1'b1};
         end else begin
            rem_in = trial[RemBits-1:0];
            low_in = {low_ff[QuotBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - QuotCntBits'(1);
         if (cnt_ff == QuotCntBits'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      den_ff <= den_in;
   end

   assign q_signed = neg_ff ? QuotBits'(-low_ff) : low_ff;
   assign quotient = coord_type'(q_signed[CoordBits-1:0]);
   assign busy     = busy_ff;

endmodule

// ----- rtl/polygon_clip_edge_by_edge.sv -----
// Top level: vertex buffers, clipping sequencer and result word output.
// Vertex words are taken while idle. The final clip word starts clipping or, with
// fewer than MinClipVerts clip vertices, goes straight to the output: the winding is
// found first, then each clip edge runs over the subject vertices and their crossings,
// using the shared multiply-accumulate unit and the serial divider.
// Synchronous reset empties all buffers and clears the overflow flag.
`timescale 1ns / 1ps
module polygon_clip_edge_by_edge
   import pce_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  logic      req_func,
   input  coord_type req_vertex_x,
   input  coord_type req_vertex_y,
   input  logic      req_last,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output coord_type rsp_out_x,
   output coord_type rsp_out_y,
   output logic      rsp_out_last,
   output logic      rsp_out_empty,
   output logic      rsp_overflow
);

   state_type state_ff, state_in;

   logic [SubCntBits-1:0]  scount_ff, wcount_ff, vidx_ff, oidx_ff, scount_m1;
   logic [ClipCntBits-1:0] ccount_ff, eidx_ff, n_after, ccount_m1, eidx_m1;
   logic                   ovf_ff, bank_ff, first_ff, dir_phase_ff, ycoord_ff;
   coord_type              ax_ff, ay_ff, bx_ff, by_ff, v0x_ff, v0y_ff, v1x_ff, v1y_ff;
   coord_type              rx_ff;
   diff_type               ex_ff, ey_ff;
   sgn_type                s0_ff, s1_ff, dir_ff, s_now;
   cross_type              den_ff, num_ff, num_acc;
   coord_type              out_x_ff, out_y_ff;
   logic                   out_last_ff, out_empty_ff, out_ovf_ff;

   logic        req_accept, rsp_accept, load_sub, load_clip, last_v, cross_hit, cross_fail;
   logic        push_en, push_ok, div_start, div_busy;
   logic [VertBits-1:0] push_data, clip_rdata, s_rdata, s_rdata0, s_rdata1;
   logic [ClipIdxBits-1:0] clip_raddr;
   logic [SubIdxBits-1:0]  sub_raddr, sub_waddr;
   logic        sub_wen0, sub_wen1;
   mac_ctl_type mac_ctl;
   cross_type   op_a;
   diff_type    op_b;
   acc_type     acc;
   coord_type   quot, c_rx, c_ry, s_rx, s_ry;
   diff_type    d_sy, d_sx, sx, sy, ox, oy;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_EMIT_HOLD);

   assign load_sub  = req_accept && (req_func == FUNC_SUBJECT);
   assign load_clip = req_accept && (req_func == FUNC_CLIP);
   assign n_after   = (ccount_ff < ClipCntBits'(MaxClipVerts)) ?
                      ccount_ff + ClipCntBits'(1) : ccount_ff;
   assign scount_m1 = scount_ff - SubCntBits'(1);
   assign ccount_m1 = ccount_ff - ClipCntBits'(1);
   assign eidx_m1   = eidx_ff - ClipCntBits'(1);
   assign last_v    = (vidx_ff == scount_m1);

   assign c_rx    = coord_type'(clip_rdata[VertBits-1:CoordBits]);
   assign c_ry    = coord_type'(clip_rdata[CoordBits-1:0]);
   assign s_rdata = bank_ff ? s_rdata1 : s_rdata0;
   assign s_rx    = coord_type'(s_rdata[VertBits-1:CoordBits]);
   assign s_ry    = coord_type'(s_rdata[CoordBits-1:0]);

   assign s_now   = sign_of(acc);
   assign num_acc = acc[CrossBits-1:0];
   assign cross_hit  = (s0_ff != SGN_ZERO) && (s_now == neg_sgn(s0_ff));
   assign cross_fail = (den_ff == cross_type'(0)) || (num_ff <= cross_type'(0)) ||
                       (num_ff >= den_ff);

   assign d_sy = sub_c(v1y_ff, by_ff);
   assign d_sx = sub_c(v1x_ff, bx_ff);
   assign sx   = sub_c(v1x_ff, v0x_ff);
   assign sy   = sub_c(v1y_ff, v0y_ff);
   assign ox   = sub_c(ax_ff, v0x_ff);
   assign oy   = sub_c(ay_ff, v0y_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load_clip && req_last) begin
               state_in = (n_after < ClipCntBits'(MinClipVerts)) ? ST_EMIT_SET : ST_DIR_RD0;
            end
         end
         ST_DIR_RD0:  state_in = ST_DIR_RD1;
         ST_DIR_RD1:  state_in = ST_DIR_RD2;
         ST_DIR_RD2:  state_in = ST_DIR_RD3;
         ST_DIR_RD3:  state_in = ST_SM1;
         ST_EDGE_CHK: begin
            if (scount_ff == '0 || eidx_ff == ccount_ff) begin
               state_in = ST_EMIT_SET;
            end else begin
               state_in = ST_EDGE_RA;
            end
         end
         ST_EDGE_RA:  state_in = ST_EDGE_RB;
         ST_EDGE_RB:  state_in = ST_VCAP;
         ST_VCAP:     state_in = ST_SM1;
         ST_SM1:      state_in = ST_SM2;
         ST_SM2:      state_in = ST_SM3;
         ST_SM3:      state_in = ST_SDEC;
         ST_SDEC: begin
            priority if (dir_phase_ff) begin
               state_in = ST_EDGE_CHK;
            end else if (first_ff) begin
               state_in = ST_VCAP;
            end else if (cross_hit) begin
               state_in = ST_C1;
            end else begin
               state_in = ST_POST;
            end
         end
         ST_POST:     state_in = last_v ? ST_EDGE_CHK : ST_VCAP;
         ST_C1:       state_in = ST_C2;
         ST_C2:       state_in = ST_C3;
         ST_C3:       state_in = ST_C4;
         ST_C4:       state_in = ST_C5;
         ST_C5:       state_in = ST_C6;
         ST_C6:       state_in = ST_C7;
         ST_C7:       state_in = ST_C8;
         ST_C8:       state_in = cross_fail ? ST_POST : ST_CX1;
         ST_CX1:      state_in = ST_CX2;
         ST_CX2:      state_in = ST_CX3;
         ST_CX3:      state_in = ST_CX4;
         ST_CX4:      state_in = ST_DIVW;
         ST_DIVW: begin
            if (!div_busy) begin
               state_in = ycoord_ff ? ST_CPUSH : ST_CX1;
            end
         end
         ST_CPUSH:    state_in = ST_POST;
         ST_EMIT_SET: state_in = (scount_ff == '0) ? ST_EMIT_HOLD : ST_EMIT_RD;
         ST_EMIT_RD:  state_in = ST_EMIT_LD;
         ST_EMIT_LD:  state_in = ST_EMIT_HOLD;
         ST_EMIT_HOLD: begin
            if (rsp_accept) begin
               state_in = out_last_ff ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      mac_ctl    = '{mul_sel: MUL_SIDE1, acc_op: ACC_HOLD};
      clip_raddr = '0;
      sub_raddr  = '0;
      push_en    = 1'b0;
      push_data  = {v1x_ff, v1y_ff};
      div_start  = 1'b0;
      unique case (state_ff)
         ST_DIR_RD0:  clip_raddr = ClipIdxBits'(0);
         ST_DIR_RD1:  clip_raddr = ClipIdxBits'(1);
         ST_DIR_RD2:  clip_raddr = ClipIdxBits'(2);
         ST_EDGE_CHK: clip_raddr = (eidx_ff == '0) ? ccount_m1[ClipIdxBits-1:0] :
                                                     eidx_m1[ClipIdxBits-1:0];
         ST_EDGE_RA:  clip_raddr = eidx_ff[ClipIdxBits-1:0];
         ST_EDGE_RB:  sub_raddr  = scount_m1[SubIdxBits-1:0];
         ST_SM1:      mac_ctl    = '{mul_sel: MUL_SIDE1, acc_op: ACC_HOLD};
         ST_SM2:      mac_ctl    = '{mul_sel: MUL_SIDE2, acc_op: ACC_LOAD};
         ST_SM3:      mac_ctl    = '{mul_sel: MUL_SIDE1, acc_op: ACC_SUB};
         ST_SDEC: begin
            sub_raddr = '0;
            push_en   = !dir_phase_ff && first_ff && (s_now != neg_sgn(dir_ff));
         end
         ST_POST: begin
            sub_raddr = SubIdxBits'(vidx_ff + SubCntBits'(1));
            push_en   = !last_v && (s1_ff != neg_sgn(dir_ff));
         end
         ST_C1:       mac_ctl = '{mul_sel: MUL_DEN1, acc_op: ACC_HOLD};
         ST_C2:       mac_ctl = '{mul_sel: MUL_DEN2, acc_op: ACC_LOAD};
         ST_C3:       mac_ctl = '{mul_sel: MUL_NUM1, acc_op: ACC_SUB};
         ST_C4:       mac_ctl = '{mul_sel: MUL_NUM1, acc_op: ACC_HOLD};
         ST_C5:       mac_ctl = '{mul_sel: MUL_NUM2, acc_op: ACC_LOAD};
         ST_C6:       mac_ctl = '{mul_sel: MUL_NUM2, acc_op: ACC_SUB};
         ST_CX1:      mac_ctl = '{mul_sel: MUL_BASE, acc_op: ACC_HOLD};
         ST_CX2:      mac_ctl = '{mul_sel: MUL_STEP, acc_op: ACC_LOAD};
         ST_CX3:      mac_ctl = '{mul_sel: MUL_STEP, acc_op: ACC_ADD};
         ST_CX4:      div_start = 1'b1;
         ST_CPUSH: begin
            push_en   = 1'b1;
            push_data = {rx_ff, quot};
         end
         ST_EMIT_RD:  sub_raddr = oidx_ff[SubIdxBits-1:0];
         default: begin
         end
      endcase
   end

   // Multiplier operand selection.
   always_comb begin
      unique case (mac_ctl.mul_sel)
         MUL_SIDE1: begin op_a = ext_d(ex_ff); op_b = d_sy;  end
         MUL_SIDE2: begin op_a = ext_d(ey_ff); op_b = d_sx;  end
         MUL_DEN1:  begin op_a = ext_d(sx);    op_b = ey_ff; end
         MUL_DEN2:  begin op_a = ext_d(sy);    op_b = ex_ff; end
         MUL_NUM1:  begin op_a = ext_d(ox);    op_b = ey_ff; end
         MUL_NUM2:  begin op_a = ext_d(oy);    op_b = ex_ff; end
         MUL_BASE:  begin
            op_a = den_ff;
            op_b = ycoord_ff ? ext_c(v0y_ff) : ext_c(v0x_ff);
         end
         MUL_STEP:  begin op_a = num_ff; op_b = ycoord_ff ? sy : sx; end
         default:   begin op_a = ext_d(ex_ff); op_b = d_sy;  end
      endcase
   end

   // Subject words go to the live bank; clipped vertices go to the other one.
   assign push_ok   = push_en && (wcount_ff < SubCntBits'(BufVerts));
   assign sub_waddr = (state_ff == ST_IDLE) ? scount_ff[SubIdxBits-1:0] :
                                              wcount_ff[SubIdxBits-1:0];
   assign sub_wen0  = (load_sub && scount_ff < SubCntBits'(BufVerts) && !bank_ff) ||
                      (push_ok && bank_ff);
   assign sub_wen1  = (load_sub && scount_ff < SubCntBits'(BufVerts) && bank_ff) ||
                      (push_ok && !bank_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         scount_ff <= '0;
         ccount_ff <= '0;
         ovf_ff    <= 1'b0;
         bank_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_sub) begin
            if (scount_ff < SubCntBits'(BufVerts)) begin
               scount_ff <= scount_ff + SubCntBits'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (load_clip) begin
            ccount_ff <= n_after;
            if (ccount_ff == ClipCntBits'(MaxClipVerts)) begin
               ovf_ff <= 1'b1;
            end
            if (req_last && n_after < ClipCntBits'(MinClipVerts)) begin
               scount_ff <= '0;
            end
         end
         if (push_en && !push_ok) begin
            ovf_ff <= 1'b1;
         end
         if (state_ff == ST_POST && last_v) begin
            bank_ff   <= !bank_ff;
            scount_ff <= wcount_ff;
         end
         if (rsp_accept && out_last_ff) begin
            scount_ff <= '0;
            ccount_ff <= '0;
            ovf_ff    <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         wcount_ff <= wcount_ff + SubCntBits'(1);
      end
      unique case (state_ff)
         ST_IDLE: dir_phase_ff <= 1'b1;
         ST_DIR_RD1: begin
            ax_ff <= c_rx;
            ay_ff <= c_ry;
         end
         ST_DIR_RD2, ST_EDGE_RB: begin
            bx_ff <= c_rx;
            by_ff <= c_ry;
            ex_ff <= sub_c(c_rx, ax_ff);
            ey_ff <= sub_c(c_ry, ay_ff);
            wcount_ff <= '0;
            first_ff  <= 1'b1;
         end
         ST_DIR_RD3, ST_VCAP: begin
            v1x_ff <= (state_ff == ST_DIR_RD3) ? c_rx : s_rx;
            v1y_ff <= (state_ff == ST_DIR_RD3) ? c_ry : s_ry;
         end
         ST_EDGE_RA: begin
            ax_ff <= c_rx;
            ay_ff <= c_ry;
         end
         ST_SDEC: begin
            s1_ff <= s_now;
            if (dir_phase_ff) begin
               dir_ff       <= s_now;
               dir_phase_ff <= 1'b0;
               eidx_ff      <= '0;
            end else if (first_ff) begin
               s0_ff    <= s_now;
               v0x_ff   <= v1x_ff;
               v0y_ff   <= v1y_ff;
               first_ff <= 1'b0;
               vidx_ff  <= '0;
            end
         end
         ST_POST: begin
            if (last_v) begin
               eidx_ff <= eidx_ff + ClipCntBits'(1);
            end else begin
               s0_ff   <= s1_ff;
               v0x_ff  <= v1x_ff;
               v0y_ff  <= v1y_ff;
               vidx_ff <= vidx_ff + SubCntBits'(1);
            end
         end
         ST_C4: den_ff <= num_acc;
         ST_C7: begin
            if (den_ff[CrossBits-1]) begin
               den_ff <= cross_type'(-den_ff);
               num_ff <= cross_type'(-num_acc);
            end else begin
               num_ff <= num_acc;
            end
            ycoord_ff <= 1'b0;
         end
         ST_DIVW: begin
            if (!div_busy && !ycoord_ff) begin
               rx_ff     <= quot;
               ycoord_ff <= 1'b1;
            end
         end
         ST_EMIT_SET: begin
            oidx_ff      <= '0;
            out_x_ff     <= '0;
            out_y_ff     <= '0;
            out_last_ff  <= 1'b1;
            out_empty_ff <= 1'b1;
            out_ovf_ff   <= ovf_ff;
         end
         ST_EMIT_LD: begin
            out_x_ff     <= s_rx;
            out_y_ff     <= s_ry;
            out_last_ff  <= (oidx_ff == scount_m1);
            out_empty_ff <= 1'b0;
            out_ovf_ff   <= ovf_ff;
         end
         ST_EMIT_HOLD: begin
            if (rsp_accept) begin
               oidx_ff <= oidx_ff + SubCntBits'(1);
            end
         end
         default: begin
         end
      endcase
   end

   pce_ram #(.Width(VertBits), .Depth(MaxClipVerts)) u_clip_ram (
      .clock   (clock),
      .wr_en   (load_clip && ccount_ff < ClipCntBits'(MaxClipVerts)),
      .wr_addr (ccount_ff[ClipIdxBits-1:0]),
      .wr_data ({req_vertex_x, req_vertex_y}),
      .rd_addr (clip_raddr),
      .rd_data (clip_rdata)
   );

   pce_ram #(.Width(VertBits), .Depth(BufVerts)) u_sub_ram0 (
      .clock   (clock),
      .wr_en   (sub_wen0),
      .wr_addr (sub_waddr),
      .wr_data ((state_ff == ST_IDLE) ? {req_vertex_x, req_vertex_y} : push_data),
      .rd_addr (sub_raddr),
      .rd_data (s_rdata0)
   );

   pce_ram #(.Width(VertBits), .Depth(BufVerts)) u_sub_ram1 (
      .clock   (clock),
      .wr_en   (sub_wen1),
      .wr_addr (sub_waddr),
      .wr_data ((state_ff == ST_IDLE) ? {req_vertex_x, req_vertex_y} : push_data),
      .rd_addr (sub_raddr),
      .rd_data (s_rdata1)
   );

   pce_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   pce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc),
      .divisor  (den_ff),
      .busy     (div_busy),
      .quotient (quot)
   );

   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_out_last  = out_last_ff;
   assign rsp_out_empty = out_empty_ff;
   assign rsp_overflow  = out_ovf_ff;

endmodule

// ----- rtl/pce_check.sv -----
// Port-level checks for the polygon clipper, bound to the top level.
`timescale 1ns / 1ps
module pce_check
   import pce_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_stall,
   input logic      rsp_valid,
   input logic      rsp_stall,
   input coord_type rsp_out_x,
   input coord_type rsp_out_y,
   input logic      rsp_out_last,
   input logic      rsp_out_empty,
   input logic      rsp_overflow
);

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
         && $stable(rsp_out_last) && $stable(rsp_out_empty) && $stable(rsp_overflow))
      else $error("stalled result word changed");

   // No new word is taken while results are being delivered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open during result delivery");

   // An empty result is a single zero word marked last.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_empty |-> rsp_out_last && rsp_out_x == '0 && rsp_out_y == '0)
      else $error("malformed empty result");

   // After reset the block is idle and ready.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind polygon_clip_edge_by_edge pce_check u_pce_check (.*);
